[design/gtbss_pkg.sv]
// Shared widths, codes and limits of the best-split scan.
// No dependencies; imported by gradient_tree_best_split_scan.
`default_nettype none
package gtbss_pkg;

   localparam int VAL_W       = 32;
   localparam int COL_W       = 10;
   localparam int CNT_W       = 17;
   localparam int SUM_W       = 48;
   localparam int GAIN_W      = 47;
   localparam int FRAC_BITS   = 16;
   localparam int MAX_COLUMNS = 1024;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 48;
   localparam int REQ_DATA_W  = 112;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_DATA_W  = 304;

   // quotient caps and iteration counts of the shared divider
   localparam logic [60:0] QCAP   = 61'h1000_0000_0000_0000;
   localparam logic [60:0] WCAP   = 61'h0000_8000_0000_0000;
   localparam logic [5:0]  Q_ITER = 6'd61;
   localparam logic [5:0]  W_ITER = 6'd48;

   localparam logic [SUM_W-1:0] SUM_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [SUM_W-1:0] SUM_MIN = 48'h8000_0000_0000;
   localparam logic [VAL_W-1:0] HALF_Q  = 32'h0000_8000;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_NODE_COUNT  = 3'd0,
      CSR_NODE_GRAD   = 3'd1,
      CSR_NODE_HESS   = 3'd2,
      CSR_NODE_LOSS   = 3'd3,
      CSR_NODE_PEN    = 3'd4,
      CSR_WEIGHT_PEN  = 3'd5,
      CSR_MIN_COUNT   = 3'd6,
      CSR_BINARY_MODE = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      STEP_QL = 2'd0,
      STEP_QR = 2'd1,
      STEP_WL = 2'd2,
      STEP_WR = 2'd3
   } step_type;

endpackage
`default_nettype wire

[design/gradient_tree_best_split_scan.sv]
// Best-split scan of one tree node: running sums, loss gain, leaf weights.
// Depends on gtbss_pkg; one shared 25x25 multiplier and one radix-2 divider.
//
//  channel | dir | handshake               | payload
//  req     | in  | req_tvalid/req_tready   | tdata value,gradient,hessian,column
//          |     |                         | tlast last_in_column, tuser in_node,last_of_scan
//  rsp     | out | rsp_tvalid/rsp_tready   | tdata split fields, tuser found
//  csr     | in  | csr_wen                 | csr_index, csr_wdata
//
// An entry that scores nothing passes ST_IDLE (its transfer), ST_CHECK, ST_ACCUM,
// ST_COLEND and ST_FINISH. Each scored candidate adds two loss terms (load, multiply,
// set-up, divider iterations, post) and one compare step.
// The scan end adds two weight divisions, when a split was found, and the output
// step; a zero numerator or a capped quotient cuts a term short.
// Reset is synchronous and active high. req_tready is low while an entry is in
// work; a pending result holds in the output register while the next entry enters.
`default_nettype none
module gradient_tree_best_split_scan (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   // value[31:0], gradient[63:32], hessian[95:64], column[105:96], zero pad
   input  wire logic [gtbss_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  wire logic                               req_tlast,
   // in_node[0], last_of_scan[1]
   input  wire logic [gtbss_pkg::REQ_USER_W-1:0]   req_tuser,
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   // best_feature[9:0], threshold[41:10], left_count[58:42], left_grad_sum[106:59],
   // left_hess_sum[154:107], left_weight[202:155], right_weight[250:203],
   // best_gain[297:251], zero pad
   output      logic [gtbss_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // found[0]
   output      logic                               rsp_tuser,
   input  wire logic                               csr_wen,
   input  wire logic [gtbss_pkg::CSR_ADDR_W-1:0]   csr_index,
   input  wire logic [gtbss_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import gtbss_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE, ST_CHECK, ST_ACCUM, ST_COLEND, ST_FINISH, ST_LOAD, ST_MUL,
      ST_DIVSET, ST_DIV, ST_POST, ST_GAIN, ST_OUT
   } state_type;

   // configuration
   logic        [CNT_W-1:0] node_count_ff, node_count_in;
   logic signed [SUM_W-1:0] node_grad_ff, node_grad_in;
   logic signed [SUM_W-1:0] node_hess_ff, node_hess_in;
   logic signed [SUM_W-1:0] node_loss_ff, node_loss_in;
   logic signed [31:0]      node_pen_ff, node_pen_in;
   logic        [30:0]      weight_pen_ff, weight_pen_in;
   logic        [CNT_W-1:0] min_count_ff, min_count_in;
   logic                    binary_ff, binary_in;

   // entry in work
   logic signed [VAL_W-1:0] ent_value_ff, ent_value_in;
   logic signed [VAL_W-1:0] ent_grad_ff, ent_grad_in;
   logic signed [VAL_W-1:0] ent_hess_ff, ent_hess_in;
   logic                    ent_in_node_ff, ent_in_node_in;
   logic        [COL_W-1:0] ent_col_ff, ent_col_in;
   logic                    ent_col_end_ff, ent_col_end_in;
   logic                    ent_scan_end_ff, ent_scan_end_in;

   // column state
   logic        [CNT_W-1:0] run_count_ff, run_count_in;
   logic signed [SUM_W-1:0] run_grad_ff, run_grad_in;
   logic signed [SUM_W-1:0] run_hess_ff, run_hess_in;
   logic signed [VAL_W-1:0] prev_ff, prev_in;
   logic                    have_prev_ff, have_prev_in;
   logic                    stopped_ff, stopped_in;

   // best split
   logic       [GAIN_W-1:0] best_gain_ff, best_gain_in;
   logic        [COL_W-1:0] best_col_ff, best_col_in;
   logic signed [VAL_W-1:0] best_thr_ff, best_thr_in;
   logic        [CNT_W-1:0] best_lc_ff, best_lc_in;
   logic signed [SUM_W-1:0] best_lg_ff, best_lg_in;
   logic signed [SUM_W-1:0] best_lh_ff, best_lh_in;

   // sequencer and shared unit
   state_type               state_ff, state_in;
   state_type               ret_ff, ret_in;
   step_type                step_ff, step_in;
   logic signed [VAL_W-1:0] thr_ff, thr_in;
   logic                    g_neg_ff, g_neg_in;
   logic                    d_neg_ff, d_neg_in;
   logic        [48:0]      mag_ff, mag_in;
   logic        [49:0]      dmag_ff, dmag_in;
   logic        [50:0]      ddiv_ff, ddiv_in;
   logic        [96:0]      acc_ff, acc_in;
   logic        [49:0]      prod_ff, prod_in;
   logic        [52:0]      rem_ff, rem_in;
   logic        [60:0]      low_ff, low_in;
   logic        [60:0]      quo_ff, quo_in;
   logic        [60:0]      res_ff, res_in;
   logic        [5:0]       cnt_ff, cnt_in;
   logic signed [63:0]      gain_ff, gain_in;
   logic signed [SUM_W-1:0] wl_ff, wl_in;
   logic signed [SUM_W-1:0] wr_ff, wr_in;

   // output register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   logic                    rsp_found_ff, rsp_found_in;

   // combinational helpers
   logic signed [18:0]      n_minus_run;
   logic                    short_right;
   logic                    run_ge_min;
   logic                    col_ok;
   logic signed [32:0]      pair_sum;
   logic signed [32:0]      pair_adj;
   logic signed [48:0]      grad_acc;
   logic signed [48:0]      hess_acc;
   logic                    is_w;
   logic                    is_right;
   logic signed [SUM_W-1:0] gsrc;
   logic signed [SUM_W-1:0] hsrc;
   logic signed [48:0]      g_op;
   logic signed [49:0]      d_op;
   logic        [24:0]      mul_a;
   logic        [24:0]      mul_b;
   logic        [96:0]      rem0;
   logic        [50:0]      ddiv_new;
   logic        [52:0]      trial;
   logic                    trial_ge;
   logic        [60:0]      quo_next;
   logic        [60:0]      cap;
   logic signed [63:0]      sq;
   logic signed [63:0]      gain_cap;
   logic signed [SUM_W-1:0] wval;
   logic                    found;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   always_comb begin
      n_minus_run = $signed({2'b00, node_count_ff}) - $signed({2'b00, run_count_ff});
      short_right = n_minus_run < $signed({2'b00, min_count_ff});
      run_ge_min  = run_count_ff >= min_count_ff;
      col_ok      = 32'(ent_col_ff) < MAX_COLUMNS;
      pair_sum    = 33'(ent_value_ff) + 33'(prev_ff);
      pair_adj    = pair_sum + $signed({32'd0, pair_sum[32]});
      grad_acc    = 49'(run_grad_ff) + 49'(ent_grad_ff);
      hess_acc    = 49'(run_hess_ff) + 49'(ent_hess_ff);

      is_w     = (step_ff == STEP_WL) || (step_ff == STEP_WR);
      is_right = (step_ff == STEP_QR) || (step_ff == STEP_WR);
      gsrc     = is_w ? best_lg_ff : run_grad_ff;
      hsrc     = is_w ? best_lh_ff : run_hess_ff;
      g_op     = is_right ? 49'(node_grad_ff) - 49'(gsrc) : 49'(gsrc);
      d_op     = (is_right ? 50'(node_hess_ff) - 50'(hsrc) : 50'(hsrc))
                 + $signed({19'd0, weight_pen_ff});

      case (cnt_ff[1:0])
         2'd0:    begin mul_a = mag_ff[24:0];          mul_b = mag_ff[24:0];          end
         2'd1:    begin mul_a = mag_ff[24:0];          mul_b = {1'b0, mag_ff[48:25]}; end
         default: begin mul_a = {1'b0, mag_ff[48:25]}; mul_b = {1'b0, mag_ff[48:25]}; end
      endcase
      prod_in = 50'(mul_a) * 50'(mul_b);

      rem0     = is_w ? (acc_ff >> 48) : (acc_ff >> 61);
      ddiv_new = is_w ? {1'b0, dmag_ff} : {dmag_ff, 1'b0};
      cap      = is_w ? WCAP : QCAP;
      trial    = {rem_ff[51:0], low_ff[60]};
      trial_ge = trial >= 53'(ddiv_ff);
      quo_next = {quo_ff[59:0], trial_ge};

      sq       = d_neg_ff ? -$signed(64'(res_ff)) : $signed(64'(res_ff));
      gain_cap = (gain_ff > $signed(64'(SUM_MAX))) ? $signed(64'(SUM_MAX)) : gain_ff;
      if (g_neg_ff == d_neg_ff) begin
         wval = -$signed(48'(res_ff));
      end else if (res_ff > 61'(SUM_MAX)) begin
         wval = SUM_MAX;
      end else begin
         wval = 48'(res_ff);
      end
      found = best_gain_ff != '0;
   end

   always_comb begin
      node_count_in = node_count_ff;
      node_grad_in  = node_grad_ff;
      node_hess_in  = node_hess_ff;
      node_loss_in  = node_loss_ff;
      node_pen_in   = node_pen_ff;
      weight_pen_in = weight_pen_ff;
      min_count_in  = min_count_ff;
      binary_in     = binary_ff;

      ent_value_in    = ent_value_ff;
      ent_grad_in     = ent_grad_ff;
      ent_hess_in     = ent_hess_ff;
      ent_in_node_in  = ent_in_node_ff;
      ent_col_in      = ent_col_ff;
      ent_col_end_in  = ent_col_end_ff;
      ent_scan_end_in = ent_scan_end_ff;

      run_count_in = run_count_ff;
      run_grad_in  = run_grad_ff;
      run_hess_in  = run_hess_ff;
      prev_in      = prev_ff;
      have_prev_in = have_prev_ff;
      stopped_in   = stopped_ff;

      best_gain_in = best_gain_ff;
      best_col_in  = best_col_ff;
      best_thr_in  = best_thr_ff;
      best_lc_in   = best_lc_ff;
      best_lg_in   = best_lg_ff;
      best_lh_in   = best_lh_ff;

      state_in = state_ff;
      ret_in   = ret_ff;
      step_in  = step_ff;
      thr_in   = thr_ff;
      g_neg_in = g_neg_ff;
      d_neg_in = d_neg_ff;
      mag_in   = mag_ff;
      dmag_in  = dmag_ff;
      ddiv_in  = ddiv_ff;
      acc_in   = acc_ff;
      rem_in   = rem_ff;
      low_in   = low_ff;
      quo_in   = quo_ff;
      res_in   = res_ff;
      cnt_in   = cnt_ff;
      gain_in  = gain_ff;
      wl_in    = wl_ff;
      wr_in    = wr_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;

      if (csr_wen) begin
         case (csr_index_type'(csr_index))
            CSR_NODE_COUNT:  node_count_in = csr_wdata[CNT_W-1:0];
            CSR_NODE_GRAD:   node_grad_in  = csr_wdata;
            CSR_NODE_HESS:   node_hess_in  = csr_wdata;
            CSR_NODE_LOSS:   node_loss_in  = csr_wdata;
            CSR_NODE_PEN:    node_pen_in   = csr_wdata[31:0];
            CSR_WEIGHT_PEN:  weight_pen_in = csr_wdata[30:0];
            CSR_MIN_COUNT:   min_count_in  = csr_wdata[CNT_W-1:0];
            CSR_BINARY_MODE: binary_in     = csr_wdata[0];
            default:         ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               ent_value_in    = req_tdata[31:0];
               ent_grad_in     = req_tdata[63:32];
               ent_hess_in     = req_tdata[95:64];
               ent_col_in      = req_tdata[105:96];
               ent_in_node_in  = req_tuser[0];
               ent_scan_end_in = req_tuser[1];
               ent_col_end_in  = req_tlast;
               state_in        = ST_CHECK;
            end
         end
         ST_CHECK: begin
            stopped_in = stopped_ff || short_right;
            state_in   = ST_ACCUM;
            if (!(stopped_ff || short_right) && ent_in_node_ff && !binary_ff && have_prev_ff
                && (ent_value_ff < prev_ff) && run_ge_min && col_ok) begin
               thr_in   = pair_adj[32:1];
               step_in  = STEP_QL;
               ret_in   = ST_ACCUM;
               state_in = ST_LOAD;
            end
         end
         ST_ACCUM: begin
            if (!stopped_ff && ent_in_node_ff) begin
               if (!binary_ff) begin
                  prev_in      = ent_value_ff;
                  have_prev_in = 1'b1;
               end
               if (run_count_ff != '1) begin
                  run_count_in = run_count_ff + 1'b1;
               end
               run_grad_in = (grad_acc[48] != grad_acc[47]) ?
                             (grad_acc[48] ? SUM_MIN : SUM_MAX) : grad_acc[47:0];
               run_hess_in = (hess_acc[48] != hess_acc[47]) ?
                             (hess_acc[48] ? SUM_MIN : SUM_MAX) : hess_acc[47:0];
            end
            state_in = ST_COLEND;
         end
         ST_COLEND: begin
            state_in = ST_FINISH;
            if ((ent_col_end_ff || ent_scan_end_ff) && run_ge_min && !short_right && col_ok) begin
               thr_in   = binary_ff ? HALF_Q : prev_ff;
               step_in  = STEP_QL;
               ret_in   = ST_FINISH;
               state_in = ST_LOAD;
            end
         end
         ST_FINISH: begin
            if (ent_col_end_ff || ent_scan_end_ff) begin
               run_count_in = '0;
               run_grad_in  = '0;
               run_hess_in  = '0;
               prev_in      = '0;
               have_prev_in = 1'b0;
               stopped_in   = 1'b0;
            end
            if (!ent_scan_end_ff) begin
               state_in = ST_IDLE;
            end else if (found) begin
               step_in  = STEP_WL;
               state_in = ST_LOAD;
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_LOAD: begin
            g_neg_in = g_op < 0;
            d_neg_in = d_op < 0;
            mag_in   = 49'(g_op < 0 ? -g_op : g_op);
            dmag_in  = 50'(d_op < 0 ? -d_op : d_op);
            cnt_in   = '0;
            if (g_op == 0) begin
               res_in   = '0;
               state_in = ST_POST;
            end else if (d_op == 0) begin
               res_in   = is_w ? WCAP : QCAP;
               state_in = ST_POST;
            end else if (is_w) begin
               acc_in   = 97'(g_op < 0 ? -g_op : g_op) << FRAC_BITS;
               state_in = ST_DIVSET;
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // square of the magnitude from three partial products
            cnt_in = cnt_ff + 1'b1;
            case (cnt_ff[1:0])
               2'd0:    acc_in = '0;
               2'd1:    acc_in = 97'(prod_ff);
               2'd2:    acc_in = acc_ff + (97'(prod_ff) << 26);
               default: begin
                  acc_in   = acc_ff + (97'(prod_ff) << 50);
                  state_in = ST_DIVSET;
               end
            endcase
         end
         ST_DIVSET: begin
            ddiv_in = ddiv_new;
            if (rem0 >= 97'(ddiv_new)) begin
               res_in   = cap;
               state_in = ST_POST;
            end else begin
               rem_in   = 53'(rem0);
               low_in   = is_w ? {acc_ff[47:0], 13'd0} : acc_ff[60:0];
               quo_in   = '0;
               cnt_in   = is_w ? W_ITER : Q_ITER;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial - 53'(ddiv_ff) : trial;
            low_in = {low_ff[59:0], 1'b0};
            quo_in = quo_next;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 6'd1) begin
               res_in   = (quo_next > cap) ? cap : quo_next;
               state_in = ST_POST;
            end
         end
         ST_POST: begin
            case (step_ff)
               STEP_QL: begin
                  gain_in  = 64'(node_loss_ff) - (64'(node_pen_ff) <<< 1) + sq;
                  step_in  = STEP_QR;
                  state_in = ST_LOAD;
               end
               STEP_QR: begin
                  gain_in  = gain_ff + sq;
                  state_in = ST_GAIN;
               end
               STEP_WL: begin
                  wl_in    = wval;
                  step_in  = STEP_WR;
                  state_in = ST_LOAD;
               end
               default: begin
                  wr_in    = wval;
                  state_in = ST_OUT;
               end
            endcase
         end
         ST_GAIN: begin
            if (gain_cap > $signed({17'd0, best_gain_ff})) begin
               best_gain_in = gain_cap[GAIN_W-1:0];
               best_col_in  = ent_col_ff;
               best_thr_in  = thr_ff;
               best_lc_in   = run_count_ff;
               best_lg_in   = run_grad_ff;
               best_lh_in   = run_hess_ff;
            end
            state_in = ret_ff;
         end
         ST_OUT: begin
            // hold until the previous result has been taken
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found;
               rsp_data_in  = '0;
               if (found) begin
                  rsp_data_in[9:0]     = best_col_ff;
                  rsp_data_in[41:10]   = best_thr_ff;
                  rsp_data_in[58:42]   = best_lc_ff;
                  rsp_data_in[106:59]  = best_lg_ff;
                  rsp_data_in[154:107] = best_lh_ff;
                  rsp_data_in[202:155] = wl_ff;
                  rsp_data_in[250:203] = wr_ff;
                  rsp_data_in[297:251] = best_gain_ff;
               end
               best_gain_in = '0;
               best_col_in  = '0;
               best_thr_in  = '0;
               best_lc_in   = '0;
               best_lg_in   = '0;
               best_lh_in   = '0;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
         node_grad_ff  <= '0;
         node_hess_ff  <= '0;
         node_loss_ff  <= '0;
         node_pen_ff   <= '0;
         weight_pen_ff <= 31'h0001_0000;
         min_count_ff  <= 17'd1;
         binary_ff     <= 1'b0;
         run_count_ff  <= '0;
         run_grad_ff   <= '0;
         run_hess_ff   <= '0;
         prev_ff       <= '0;
         have_prev_ff  <= 1'b0;
         stopped_ff    <= 1'b0;
         best_gain_ff  <= '0;
         best_col_ff   <= '0;
         best_thr_ff   <= '0;
         best_lc_ff    <= '0;
         best_lg_ff    <= '0;
         best_lh_ff    <= '0;
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         step_ff       <= STEP_QL;
         rsp_valid_ff  <= 1'b0;
      end else begin
         node_count_ff <= node_count_in;
         node_grad_ff  <= node_grad_in;
         node_hess_ff  <= node_hess_in;
         node_loss_ff  <= node_loss_in;
         node_pen_ff   <= node_pen_in;
         weight_pen_ff <= weight_pen_in;
         min_count_ff  <= min_count_in;
         binary_ff     <= binary_in;
         run_count_ff  <= run_count_in;
         run_grad_ff   <= run_grad_in;
         run_hess_ff   <= run_hess_in;
         prev_ff       <= prev_in;
         have_prev_ff  <= have_prev_in;
         stopped_ff    <= stopped_in;
         best_gain_ff  <= best_gain_in;
         best_col_ff   <= best_col_in;
         best_thr_ff   <= best_thr_in;
         best_lc_ff    <= best_lc_in;
         best_lg_ff    <= best_lg_in;
         best_lh_ff    <= best_lh_in;
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         step_ff       <= step_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      ent_value_ff    <= ent_value_in;
      ent_grad_ff     <= ent_grad_in;
      ent_hess_ff     <= ent_hess_in;
      ent_in_node_ff  <= ent_in_node_in;
      ent_col_ff      <= ent_col_in;
      ent_col_end_ff  <= ent_col_end_in;
      ent_scan_end_ff <= ent_scan_end_in;
      thr_ff          <= thr_in;
      g_neg_ff        <= g_neg_in;
      d_neg_ff        <= d_neg_in;
      mag_ff          <= mag_in;
      dmag_ff         <= dmag_in;
      ddiv_ff         <= ddiv_in;
      acc_ff          <= acc_in;
      prod_ff         <= prod_in;
      rem_ff          <= rem_in;
      low_ff          <= low_in;
      quo_ff          <= quo_in;
      res_ff          <= res_in;
      cnt_ff          <= cnt_in;
      gain_ff         <= gain_in;
      wl_ff           <= wl_in;
      wr_ff           <= wr_in;
      rsp_data_ff     <= rsp_data_in;
      rsp_found_ff    <= rsp_found_in;
   end

endmodule
`default_nettype wire
